// ===== sv/bim_pkg.sv =====
package bim_pkg;

  // field widths
  localparam int COORD_W  = 16;
  localparam int KIND_W   = 2;
  localparam int PIDX_W   = 8;
  localparam int WIDX_W   = 4;
  localparam int IOU_W    = 17;
  localparam int RCNT_W   = 5;

  // iou of exactly one in q1.16
  localparam logic [IOU_W-1:0] IOU_ONE = 17'h10000;
  // threshold after reset, one half
  localparam logic [IOU_W-1:0] THRESH_RESET = 17'h08000;
  // results one person query may emit
  localparam logic [RCNT_W-1:0] RESULT_LIMIT = 5'd16;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WEAPON = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PERSON = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] y_max;
    logic [COORD_W-1:0] x_max;
    logic [COORD_W-1:0] y_min;
    logic [COORD_W-1:0] x_min;
  } box_t;

  typedef struct packed {
    logic [PIDX_W-1:0] person_index;
    logic [WIDX_W-1:0] weapon_index;
    logic [IOU_W-1:0]  iou_value;
    logic              is_summary;
    logic              any_match;
    logic              overflow;
    logic              last;
  } res_t;

  // status from the iou unit
  typedef struct packed {
    logic             done;
    logic [IOU_W-1:0] iou;
  } iou_stat_t;

endpackage

// ===== sv/bim_box_if.sv =====
interface bim_box_if;
  logic                         valid;
  logic                         ready;
  logic [bim_pkg::KIND_W-1:0]   kind;
  logic [bim_pkg::COORD_W-1:0]  x_min;
  logic [bim_pkg::COORD_W-1:0]  y_min;
  logic [bim_pkg::COORD_W-1:0]  x_max;
  logic [bim_pkg::COORD_W-1:0]  y_max;

  modport source (output valid, kind, x_min, y_min, x_max, y_max, input ready);
  modport sink (input valid, kind, x_min, y_min, x_max, y_max, output ready);
endinterface

// ===== sv/bim_res_if.sv =====
interface bim_res_if;
  logic                         valid;
  logic                         ready;
  logic [bim_pkg::PIDX_W-1:0]   person_index;
  logic [bim_pkg::WIDX_W-1:0]   weapon_index;
  logic [bim_pkg::IOU_W-1:0]    iou_value;
  logic                         is_summary;
  logic                         any_match;
  logic                         overflow;
  logic                         last;

  modport source (output valid, person_index, weapon_index, iou_value, is_summary,
                  any_match, overflow, last, input ready);
  modport sink (input valid, person_index, weapon_index, iou_value, is_summary,
                any_match, overflow, last, output ready);
endinterface

// ===== sv/bim_cfg_if.sv =====
interface bim_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bim_pkg::IOU_W-1:0]    threshold;

  modport source (output valid, threshold, input ready);
  modport sink (input valid, threshold, output ready);
endinterface

// ===== sv/bim_iou.sv =====
module bim_iou (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  bim_pkg::box_t      box_a,
  input  bim_pkg::box_t      box_b,
  output bim_pkg::iou_stat_t stat
);

  typedef enum logic [2:0] {I_IDLE, I_EDGE, I_MUL, I_UNION, I_DIV} istate_t;
  typedef enum logic [1:0] {M_INTER, M_AREA_A, M_AREA_B} mstep_t;

  istate_t                     istate;
  mstep_t                      mstep;
  bim_pkg::box_t               a;
  bim_pkg::box_t               b;
  logic                        empty;
  logic [bim_pkg::COORD_W-1:0] dx;
  logic [bim_pkg::COORD_W-1:0] dy;
  logic signed [16:0]          adx;
  logic signed [16:0]          ady;
  logic signed [16:0]          bdx;
  logic signed [16:0]          bdy;
  logic [31:0]                 inter;
  logic signed [33:0]          area_a;
  logic signed [33:0]          area_b;
  logic [33:0]                 den;
  logic [34:0]                 rem;
  logic [15:0]                 quo;
  logic [3:0]                  div_cnt;

  logic [bim_pkg::COORD_W-1:0] ix0, iy0, ix1, iy1;
  logic signed [16:0]          mul_x, mul_y;
  logic signed [33:0]          prod;
  logic signed [35:0]          uni;
  logic [35:0]                 trial;
  logic                        fits;

  // intersection edges
  assign ix0 = (a.x_min > b.x_min) ? a.x_min : b.x_min;
  assign iy0 = (a.y_min > b.y_min) ? a.y_min : b.y_min;
  assign ix1 = (a.x_max < b.x_max) ? a.x_max : b.x_max;
  assign iy1 = (a.y_max < b.y_max) ? a.y_max : b.y_max;

  // shared multiplier operand select
  always_comb begin
    case (mstep)
      M_INTER: begin
        mul_x = $signed({1'b0, dx});
        mul_y = $signed({1'b0, dy});
      end
      M_AREA_A: begin
        mul_x = adx;
        mul_y = ady;
      end
      default: begin
        mul_x = bdx;
        mul_y = bdy;
      end
    endcase
  end

  assign prod = mul_x * mul_y;

  // union of the two areas
  assign uni = $signed({{2{area_a[33]}}, area_a}) + $signed({{2{area_b[33]}}, area_b})
             - $signed({4'b0, inter});

  // one restoring division step
  assign trial = {rem, 1'b0} - {2'b0, den};
  assign fits  = !trial[35];

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      istate    <= I_IDLE;
      stat.done <= 1'b0;
    end else begin
      case (istate)
        I_IDLE: begin
          stat.done <= 1'b0;
          if (start) begin
            a      <= box_a;
            b      <= box_b;
            istate <= I_EDGE;
          end
        end
        I_EDGE: begin
          stat.done <= 1'b0;
          empty  <= (ix1 <= ix0) || (iy1 <= iy0);
          dx     <= ix1 - ix0;
          dy     <= iy1 - iy0;
          adx    <= $signed({1'b0, a.x_max}) - $signed({1'b0, a.x_min});
          ady    <= $signed({1'b0, a.y_max}) - $signed({1'b0, a.y_min});
          bdx    <= $signed({1'b0, b.x_max}) - $signed({1'b0, b.x_min});
          bdy    <= $signed({1'b0, b.y_max}) - $signed({1'b0, b.y_min});
          mstep  <= M_INTER;
          istate <= I_MUL;
        end
        I_MUL: begin
          stat.done <= 1'b0;
          case (mstep)
            M_INTER: begin
              inter <= prod[31:0];
              mstep <= M_AREA_A;
            end
            M_AREA_A: begin
              area_a <= prod;
              mstep  <= M_AREA_B;
            end
            default: begin
              area_b <= prod;
              istate <= I_UNION;
            end
          endcase
        end
        I_UNION: begin
          if (empty || uni <= 36'sd0) begin
            stat.iou  <= '0;
            stat.done <= 1'b1;
            istate    <= I_IDLE;
          end else if ($signed({4'b0, inter}) >= uni) begin
            // ratio of one or more saturates
            stat.iou  <= bim_pkg::IOU_ONE;
            stat.done <= 1'b1;
            istate    <= I_IDLE;
          end else begin
            stat.done <= 1'b0;
            rem     <= {3'b0, inter};
            den     <= uni[33:0];
            quo     <= '0;
            div_cnt <= 4'd15;
            istate  <= I_DIV;
          end
        end
        I_DIV: begin
          rem <= fits ? trial[34:0] : {rem[33:0], 1'b0};
          quo <= {quo[14:0], fits};
          if (div_cnt == 4'd0) begin
            stat.iou  <= {1'b0, quo[14:0], fits};
            stat.done <= 1'b1;
            istate    <= I_IDLE;
          end else begin
            stat.done <= 1'b0;
            div_cnt <= div_cnt - 4'd1;
          end
        end
        default: begin
          stat.done <= 1'b0;
          istate    <= I_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/box_iou_threshold_matcher.sv =====
// Pairwise box matcher for weapon and person boxes.
// Requests on boxes carry a kind and a box in unsigned q12.4 pixels:
// clear opens a frame, weapon stores a box (up to MAX_WEAPONS), person
// compares its box with every stored weapon box in store order, end emits
// a summary with the any-match and overflow flags.
// Each pair whose iou (q1.16, floored) reaches the threshold gives one
// result on results, up to 16 per person request; last marks the final result of a request.
// The user must write the threshold through cfg only while the block is idle; the block does not enforce this.
// Clear and weapon requests are accepted back to back; an end request passes
// through the summary state, which waits for a free output register.
// A person request runs for each stored weapon: memory read, start,
// edge compare, three passes through the shared 17x17 multiplier, union
// check, 16 restoring division steps, result check and step to the next
// weapon; a pair without overlap or with a saturated ratio skips the
// division. Passing a held result to the output adds the emit state,
// and boxes.ready stays low from the accept of a person request until
// the sequencer returns to idle.
// Results wait in an output register plus one pending result; a stalled
// receiver holds the sequencer until the register frees.
// Reset empties the frame and sets the threshold to one half.
module box_iou_threshold_matcher #(
  parameter int MAX_WEAPONS = 16,
  parameter int MAX_PERSONS = 256
) (
  input  logic       clk,
  input  logic       rst,
  bim_box_if.sink    boxes,
  bim_res_if.source  results,
  bim_cfg_if.sink    cfg
);

  localparam int WA  = (MAX_WEAPONS > 1) ? $clog2(MAX_WEAPONS) : 1;
  localparam int WCW = $clog2(MAX_WEAPONS + 1);
  localparam int PCW = $clog2(MAX_PERSONS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_READ, S_CALC, S_WAIT, S_EMIT, S_NEXT, S_FLUSH
  } state_t;

  state_t                      state;
  logic [WCW-1:0]              weapon_count;
  logic [PCW-1:0]              person_count;
  logic                        match_seen;
  logic                        dropped_flag;
  logic [bim_pkg::IOU_W-1:0]   threshold;
  bim_pkg::box_t               person;
  logic [WCW-1:0]              w;
  logic [bim_pkg::RCNT_W-1:0]  n;
  bim_pkg::res_t               pend;
  logic                        pend_valid;
  bim_pkg::res_t               cand;
  bim_pkg::res_t               out_reg;
  logic                        out_valid;
  bim_pkg::box_t               mem [MAX_WEAPONS];
  bim_pkg::box_t               rdata;

  bim_pkg::box_t               box_in;
  bim_pkg::iou_stat_t          iou_stat;
  bim_pkg::res_t               new_res;
  bim_pkg::res_t               sum_res;
  bim_pkg::res_t               flush_res;
  logic                        in_acc;
  logic                        out_free;
  logic                        out_load;
  logic                        last_w;
  logic                        hit;
  logic                        mem_we;
  logic [WCW+3:0]              w_ext;
  logic [PCW+7:0]              p_ext;

  // handshake
  assign boxes.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign in_acc      = boxes.valid && boxes.ready;
  assign out_free    = !out_valid || results.ready;
  assign out_load    = out_free && ((state == S_SUM) || (state == S_EMIT)
                    || ((state == S_FLUSH) && pend_valid));

  assign box_in.x_min = boxes.x_min;
  assign box_in.y_min = boxes.y_min;
  assign box_in.x_max = boxes.x_max;
  assign box_in.y_max = boxes.y_max;

  // weapon loop control
  assign last_w = ((w + WCW'(1)) == weapon_count);
  assign hit    = (iou_stat.iou >= threshold);
  assign mem_we = in_acc && (boxes.kind == bim_pkg::KIND_WEAPON)
               && (weapon_count != WCW'(MAX_WEAPONS));

  // indexes wrap to the output field widths
  assign w_ext = {4'b0, w};
  assign p_ext = {8'b0, person_count};

  // match, summary and final results
  always_comb begin
    new_res              = '0;
    new_res.person_index = p_ext[bim_pkg::PIDX_W-1:0];
    new_res.weapon_index = w_ext[bim_pkg::WIDX_W-1:0];
    new_res.iou_value    = iou_stat.iou;
    sum_res              = '0;
    sum_res.is_summary   = 1'b1;
    sum_res.any_match    = match_seen;
    sum_res.overflow     = dropped_flag;
    sum_res.last         = 1'b1;
    flush_res            = pend;
    flush_res.last       = 1'b1;
  end

  // shared iou unit
  bim_iou u_iou (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_CALC),
    .box_a (person),
    .box_b (rdata),
    .stat  (iou_stat)
  );

  // weapon box memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[weapon_count[WA-1:0]] <= box_in;
    end
    if (state == S_READ) begin
      rdata <= mem[w[WA-1:0]];
    end
  end

  // sequencer, frame state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      weapon_count <= '0;
      person_count <= '0;
      match_seen   <= 1'b0;
      dropped_flag <= 1'b0;
      threshold    <= bim_pkg::THRESH_RESET;
      out_valid    <= 1'b0;
      pend_valid   <= 1'b0;
      n            <= '0;
      w            <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        threshold <= cfg.threshold;
      end
      out_valid <= out_load || (out_valid && !results.ready);
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (boxes.kind)
              bim_pkg::KIND_CLEAR: begin
                weapon_count <= '0;
                person_count <= '0;
                match_seen   <= 1'b0;
                dropped_flag <= 1'b0;
              end
              bim_pkg::KIND_WEAPON: begin
                if (weapon_count == WCW'(MAX_WEAPONS)) begin
                  dropped_flag <= 1'b1;
                end else begin
                  weapon_count <= weapon_count + WCW'(1);
                end
              end
              bim_pkg::KIND_PERSON: begin
                if (person_count == PCW'(MAX_PERSONS)) begin
                  dropped_flag <= 1'b1;
                end else if (weapon_count == '0) begin
                  person_count <= person_count + PCW'(1);
                end else begin
                  person     <= box_in;
                  w          <= '0;
                  n          <= '0;
                  pend_valid <= 1'b0;
                  state      <= S_READ;
                end
              end
              bim_pkg::KIND_END: state <= S_SUM;
              default: ;
            endcase
          end
        end
        // frame summary
        S_SUM: begin
          if (out_free) begin
            out_reg <= sum_res;
            state   <= S_IDLE;
          end
        end
        S_READ: state <= S_CALC;
        S_CALC: state <= S_WAIT;
        // one result is held back so that last can be set on it
        S_WAIT: begin
          if (iou_stat.done) begin
            if (hit) begin
              match_seen <= 1'b1;
            end
            if (hit && (n < bim_pkg::RESULT_LIMIT)) begin
              n <= n + bim_pkg::RCNT_W'(1);
              if (pend_valid) begin
                cand  <= new_res;
                state <= S_EMIT;
              end else begin
                pend       <= new_res;
                pend_valid <= 1'b1;
                state      <= S_NEXT;
              end
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_reg <= pend;
            pend    <= cand;
            state   <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (last_w) begin
            state <= S_FLUSH;
          end else begin
            w     <= w + WCW'(1);
            state <= S_READ;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            person_count <= person_count + PCW'(1);
            state        <= S_IDLE;
          end else if (out_free) begin
            out_reg      <= flush_res;
            pend_valid   <= 1'b0;
            person_count <= person_count + PCW'(1);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result port
  assign results.valid        = out_valid;
  assign results.person_index = out_reg.person_index;
  assign results.weapon_index = out_reg.weapon_index;
  assign results.iou_value    = out_reg.iou_value;
  assign results.is_summary   = out_reg.is_summary;
  assign results.any_match    = out_reg.any_match;
  assign results.overflow     = out_reg.overflow;
  assign results.last         = out_reg.last;

  // checks
  a_weapon_cap: assert property (@(posedge clk) disable iff (rst)
    weapon_count <= WCW'(MAX_WEAPONS))
    else $error("weapon count above capacity");

  a_person_cap: assert property (@(posedge clk) disable iff (rst)
    person_count <= PCW'(MAX_PERSONS))
    else $error("person count above capacity");

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    iou_stat.done |-> (state == S_WAIT))
    else $error("iou unit finished outside the wait state");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("held result left behind after a person request");

endmodule
